>>> src/spbm_pkg.sv
// Shared constants and types for the stable partition by magnitude block.
`default_nettype none

package spbm_pkg;

  // Width of one signed Q16.16 sample word.
  localparam int unsigned SampleW = 32;

  // Default number of entries in the small-sample buffer.
  localparam int unsigned BufferDepthDefault = 32;

  // One signed Q16.16 sample word.
  typedef logic signed [SampleW-1:0] sample_t;

endpackage

`default_nettype wire

>>> src/spbm_classify.sv
// Magnitude classifier: saturating absolute value compared against the threshold.
`default_nettype none

module spbm_classify (
  input  spbm_pkg::sample_t sample_i,
  input  spbm_pkg::sample_t threshold_i,
  output logic              is_large_o
);

  localparam int unsigned MagW = spbm_pkg::SampleW - 1;

  logic [spbm_pkg::SampleW-1:0] neg_w;
  logic [MagW-1:0]              mag_w;
  logic                         is_min_w;

  // Absolute value. The most negative word has no positive twin and saturates.
  always_comb begin
    neg_w    = spbm_pkg::SampleW'(-sample_i);
    is_min_w = sample_i[spbm_pkg::SampleW-1] && (sample_i[MagW-1:0] == '0);
    if (!sample_i[spbm_pkg::SampleW-1]) begin
      mag_w = sample_i[MagW-1:0];
    end else if (is_min_w) begin
      mag_w = '1;
    end else begin
      mag_w = neg_w[MagW-1:0];
    end
  end

  // A negative threshold makes every sample large; otherwise compare magnitudes.
  assign is_large_o = threshold_i[spbm_pkg::SampleW-1] || (mag_w > threshold_i[MagW-1:0]);

endmodule

`default_nettype wire

>>> src/spbm_buffer.sv
// Small-sample buffer: one write port and one registered read port.
`default_nettype none

module spbm_buffer #(
  parameter int unsigned Depth = spbm_pkg::BufferDepthDefault,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire               clk_i,
  input  wire               wr_en_i,
  input  wire [AddrW-1:0]   wr_addr_i,
  input  spbm_pkg::sample_t wr_data_i,
  input  wire               rd_en_i,
  input  wire [AddrW-1:0]   rd_addr_i,
  output spbm_pkg::sample_t rd_data_o
);

  spbm_pkg::sample_t mem_q [Depth];
  spbm_pkg::sample_t rd_data_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port; the word holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

>>> src/stable_partition_by_magnitude.sv
// A large sample appears on the output in the cycle after it is accepted.
// Throughput: one sample per cycle outside a flush while the output word is taken.
// At the end of a run the input closes while the buffer flushes its N buffered
// samples, one word per cycle through the registered read port while the output is taken.
// Reset clears the threshold, the buffer count, the drop flag and the output valid;
// buffer contents are not cleared and are only read after being written.
`default_nettype none

module stable_partition_by_magnitude #(
  parameter int unsigned BUFFER_DEPTH = spbm_pkg::BufferDepthDefault
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               cfg_we_i,
  input  spbm_pkg::sample_t cfg_wdata_i,
  input  wire               in_valid_i,
  output logic              in_ready_o,
  input  spbm_pkg::sample_t sample_value_i,
  input  wire               is_final_i,
  output logic              out_valid_o,
  input  wire               out_ready_i,
  output spbm_pkg::sample_t out_value_o,
  output logic              run_end_o,
  output logic              overflow_seen_o
);

  localparam int unsigned CntW  = $clog2(BUFFER_DEPTH + 1);
  localparam int unsigned AddrW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam logic [CntW-1:0] DepthC = CntW'(BUFFER_DEPTH);

  localparam logic ST_RUN   = 1'b0;
  localparam logic ST_FLUSH = 1'b1;

  logic              state_q, state_d;
  spbm_pkg::sample_t threshold_q;
  logic [CntW-1:0]   count_q, count_d;
  logic              flag_q, flag_d;
  logic [CntW-1:0]   rd_idx_q, rd_idx_d;
  logic [CntW-1:0]   out_idx_q, out_idx_d;
  logic              rdata_valid_q, rdata_valid_d;
  logic              out_valid_q, out_valid_d;
  spbm_pkg::sample_t out_value_q, out_value_d;
  logic              run_end_q, run_end_d;
  logic              ovf_q, ovf_d;

  logic              is_large;
  logic              out_free;
  logic              accept;
  logic              wr_en;
  logic              drop;
  logic [CntW-1:0]   count_after;
  logic              flag_after;
  logic              rd_en;
  logic              load_flush;
  logic              flush_last;
  logic [CntW-1:0]   out_idx_inc;
  spbm_pkg::sample_t rd_data;

  // Threshold classification of the incoming word.
  spbm_classify u_classify (
    .sample_i    (sample_value_i),
    .threshold_i (threshold_q),
    .is_large_o  (is_large)
  );

  // Buffer for small samples, flushed in arrival order.
  spbm_buffer #(
    .Depth (BUFFER_DEPTH),
    .AddrW (AddrW)
  ) u_buffer (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (count_q[AddrW-1:0]),
    .wr_data_i (sample_value_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_idx_q[AddrW-1:0]),
    .rd_data_o (rd_data)
  );

  // Handshake and datapath decisions.
  always_comb begin
    out_free    = !out_valid_q || out_ready_i;
    in_ready_o  = (state_q == ST_RUN) && out_free;
    accept      = in_valid_i && in_ready_o;
    wr_en       = accept && !is_large && (count_q < DepthC);
    drop        = accept && !is_large && (count_q >= DepthC);
    count_after = count_q + CntW'(wr_en);
    flag_after  = flag_q || drop;
    load_flush  = (state_q == ST_FLUSH) && rdata_valid_q && out_free;
    out_idx_inc = CntW'(out_idx_q + 1'b1);
    flush_last  = (out_idx_inc == count_q);
    rd_en       = (state_q == ST_FLUSH) && (rd_idx_q < count_q)
                  && (!rdata_valid_q || load_flush);
  end

  // Run control and flush sequencing.
  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    flag_d        = flag_q;
    rd_idx_d      = rd_idx_q;
    out_idx_d     = out_idx_q;
    rdata_valid_d = rdata_valid_q;

    unique case (state_q)
      ST_RUN: begin
        if (accept) begin
          if (is_final_i) begin
            if (count_after == '0) begin
              count_d = '0;
              flag_d  = 1'b0;
            end else begin
              state_d = ST_FLUSH;
              count_d = count_after;
              flag_d  = flag_after;
            end
          end else begin
            count_d = count_after;
            flag_d  = flag_after;
          end
        end
      end
      ST_FLUSH: begin
        if (rd_en) begin
          rd_idx_d      = CntW'(rd_idx_q + 1'b1);
          rdata_valid_d = 1'b1;
        end else if (load_flush) begin
          rdata_valid_d = 1'b0;
        end
        if (load_flush) begin
          out_idx_d = out_idx_inc;
          if (flush_last) begin
            state_d   = ST_RUN;
            count_d   = '0;
            flag_d    = 1'b0;
            rd_idx_d  = '0;
            out_idx_d = '0;
          end
        end
      end
      default: begin
        state_d = ST_RUN;
      end
    endcase
  end

  // Output word register: a large sample in a run, or a buffered word in a flush.
  always_comb begin
    out_value_d = out_value_q;
    run_end_d   = run_end_q;
    ovf_d       = ovf_q;
    if (accept && is_large) begin
      out_value_d = sample_value_i;
      run_end_d   = is_final_i && (count_q == '0);
      ovf_d       = flag_q;
    end else if (load_flush) begin
      out_value_d = rd_data;
      run_end_d   = flush_last;
      ovf_d       = flag_q;
    end
    if ((accept && is_large) || load_flush) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_RUN;
      threshold_q   <= '0;
      count_q       <= '0;
      flag_q        <= 1'b0;
      rd_idx_q      <= '0;
      out_idx_q     <= '0;
      rdata_valid_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      count_q       <= count_d;
      flag_q        <= flag_d;
      rd_idx_q      <= rd_idx_d;
      out_idx_q     <= out_idx_d;
      rdata_valid_q <= rdata_valid_d;
      out_valid_q   <= out_valid_d;
      if (cfg_we_i) begin
        threshold_q <= cfg_wdata_i;
      end
    end
  end

  // Output payload registers.
  always_ff @(posedge clk_i) begin
    out_value_q <= out_value_d;
    run_end_q   <= run_end_d;
    ovf_q       <= ovf_d;
  end

  assign out_valid_o     = out_valid_q;
  assign out_value_o     = out_value_q;
  assign run_end_o       = run_end_q;
  assign overflow_seen_o = ovf_q;

`ifndef SYNTHESIS
  // The fill count never passes the buffer depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= DepthC)
    else $error("buffer count exceeds depth");

  // Reads issued equal words emitted plus the one word waiting in the read register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      rd_idx_q == CntW'(out_idx_q + CntW'(rdata_valid_q)))
    else $error("flush read and emit counters out of step");

  // Emitting the last flushed word empties the buffer and ends the flush.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      load_flush && flush_last |=> (count_q == '0) && (state_q == ST_RUN))
    else $error("flush did not close cleanly");
`endif

endmodule

`default_nettype wire

>>> bench/stable_partition_by_magnitude_test.sv
// Self-checking testbench for the stable partition by magnitude block.
`timescale 1ns / 100ps

module stable_partition_by_magnitude_test;

  // One signed Q16.16 sample word, as the package defines it.
  typedef spbm_pkg::sample_t sample_t;

  localparam int unsigned Depth = spbm_pkg::BufferDepthDefault;
  // Leave margin past the last result of a full flush.
  localparam int unsigned SettleCycles = Depth + 8;
  localparam int NumDirected = 11;
  localparam int NumPhases = 6;
  localparam int PhaseWords = 36;
  localparam sample_t SampleMin = 32'sh8000_0000;
  localparam sample_t SampleMax = 32'sh7FFF_FFFF;

  // One output word as the block should present it.
  typedef struct {
    sample_t value;
    logic    run_end;
    logic    overflow;
  } word_t;

  // One directed input word, with a typed result where it is obvious.
  typedef struct {
    sample_t value;
    bit      last;
    bit      known;
    sample_t out_value;
    bit      out_end;
    bit      out_overflow;
  } row_t;

  logic    clk_i;
  logic    rst_ni;
  logic    cfg_we_i;
  sample_t cfg_wdata_i;
  logic    in_valid_i;
  logic    in_ready_o;
  sample_t sample_value_i;
  logic    is_final_i;
  logic    out_valid_o;
  logic    out_ready_i;
  sample_t out_value_o;
  logic    run_end_o;
  logic    overflow_seen_o;

  // Partition state mirrored on the bench side.
  sample_t threshold_q;
  sample_t held_smalls[$];
  bit      drop_sticky;
  word_t   pending_words[$];

  int mismatch_count = 0;
  int words_sent = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // Directed words, all under the reset threshold of zero.
  row_t directed_rows [NumDirected] = '{
    '{SampleMax, 1'b1, 1'b1, SampleMax, 1'b1, 1'b0},
    '{SampleMin, 1'b1, 1'b1, SampleMin, 1'b1, 1'b0},
    '{32'sh0, 1'b1, 1'b1, 32'sh0, 1'b1, 1'b0},
    '{32'sh1, 1'b0, 1'b1, 32'sh1, 1'b0, 1'b0},
    '{32'sh0, 1'b0, 1'b0, 32'sh0, 1'b0, 1'b0},
    '{-32'sh1, 1'b0, 1'b1, -32'sh1, 1'b0, 1'b0},
    '{32'sh0, 1'b1, 1'b0, 32'sh0, 1'b0, 1'b0},
    '{32'sh0, 1'b0, 1'b0, 32'sh0, 1'b0, 1'b0},
    '{32'sh7, 1'b1, 1'b0, 32'sh0, 1'b0, 1'b0},
    '{32'sh0001_0000, 1'b0, 1'b1, 32'sh0001_0000, 1'b0, 1'b0},
    '{-32'sh0001_0000, 1'b1, 1'b1, -32'sh0001_0000, 1'b1, 1'b0}
  };

  // Thresholds of the random phases; the last phase draws its own.
  sample_t phase_thresholds [NumPhases-1] = '{
    32'sh0001_0000, -32'sh1, SampleMax, SampleMin, 32'sh0
  };

  stable_partition_by_magnitude DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .sample_value_i (sample_value_i),
    .is_final_i     (is_final_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_value_o    (out_value_o),
    .run_end_o      (run_end_o),
    .overflow_seen_o(overflow_seen_o)
  );

  // 10 ns clock.
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Magnitude on the raw Q16.16 bits, saturating at the most negative value.
  function automatic longint magnitude_of(input sample_t v);
    if (v == SampleMin) return 64'h7FFF_FFFF;
    return (v < 0) ? -longint'(v) : longint'(v);
  endfunction

  // Works out the words caused by one accepted sample and updates the state.
  function automatic void partition_sample(input sample_t v, input bit last,
                                           ref word_t produced[$]);
    bit is_big;
    is_big = magnitude_of(v) > longint'(threshold_q);
    if (is_big) begin
      produced.push_back('{v, last && held_smalls.size() == 0, drop_sticky});
    end else if (held_smalls.size() < Depth) begin
      held_smalls.push_back(v);
    end else begin
      drop_sticky = 1'b1;
    end
    // The closing word flushes the held small samples in arrival order.
    if (last) begin
      foreach (held_smalls[i]) begin
        produced.push_back('{held_smalls[i], i == held_smalls.size() - 1, drop_sticky});
      end
      held_smalls.delete();
      drop_sticky = 1'b0;
    end
  endfunction

  // Random sample: full range, extremes, values around the threshold, small ones.
  function automatic sample_t pick_sample();
    sample_t v;
    case ($urandom_range(0, 7))
      0, 1: v = $urandom;
      2: begin
        case ($urandom_range(0, 3))
          0: v = SampleMin;
          1: v = SampleMax;
          2: v = 32'sh0;
          default: v = -32'sh1;
        endcase
      end
      3, 4: begin
        v = threshold_q + sample_t'($urandom_range(0, 4)) - 32'sh2;
        if ($urandom_range(0, 1)) v = -v;
      end
      default: begin
        v = sample_t'($urandom_range(0, 32'h0003_FFFF));
        if ($urandom_range(0, 1)) v = -v;
      end
    endcase
    return v;
  endfunction

  // Offers one input word and books its expected results once it is taken.
  // Called and returns at a falling edge.
  task automatic send_word(input sample_t v, input bit last, input bit known,
                           input word_t typed);
    word_t produced[$];
    if (words_sent < 80) begin
      send_idle_pct = 34;
      recv_idle_pct = 55;
    end else if (words_sent < 160) begin
      send_idle_pct = 55;
      recv_idle_pct = 34;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    sample_value_i <= v;
    is_final_i     <= last;
    do @(posedge clk_i); while (!in_ready_o);
    partition_sample(v, last, produced);
    if (known) begin
      pending_words.push_back(typed);
    end else begin
      foreach (produced[i]) pending_words.push_back(produced[i]);
    end
    words_sent++;
    @(negedge clk_i);
  endtask

  // Stops offering words and waits until the block has nothing left to send.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_words.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // Writes the threshold register while the block is idle.
  task automatic write_threshold(input sample_t t);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= t;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    threshold_q = t;
  endtask

  // Receiver: stalls at random, changing ready only on the falling edge.
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Compare every taken output word with the oldest expected one.
  always @(posedge clk_i) begin
    word_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_words.size() == 0) begin
        $error("out_value: no word expected, got %h", out_value_o);
        mismatch_count++;
      end else begin
        want = pending_words.pop_front();
        if (out_value_o !== want.value) begin
          $error("out_value: expected %h, got %h", want.value, out_value_o);
          mismatch_count++;
        end
        if (run_end_o !== want.run_end) begin
          $error("run_end: expected %b, got %b", want.run_end, run_end_o);
          mismatch_count++;
        end
        if (overflow_seen_o !== want.overflow) begin
          $error("overflow_seen: expected %b, got %b", want.overflow, overflow_seen_o);
          mismatch_count++;
        end
      end
    end
  end

  // Main sequence: reset, directed words, then random runs per threshold.
  initial begin
    word_t   none;
    sample_t thr;
    int      run_len;
    int      phase_count;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    in_valid_i     = 1'b0;
    sample_value_i = '0;
    is_final_i     = 1'b0;
    threshold_q    = '0;
    drop_sticky    = 1'b0;
    none           = '{'0, 1'b0, 1'b0};
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    write_threshold(32'sh0);
    foreach (directed_rows[r]) begin
      send_word(directed_rows[r].value, directed_rows[r].last, directed_rows[r].known,
                '{directed_rows[r].out_value, directed_rows[r].out_end,
                  directed_rows[r].out_overflow});
    end
    drain();

    // Each phase opens with a run long enough to overflow the buffer.
    for (int p = 0; p < NumPhases; p++) begin
      if (p < NumPhases - 1) begin
        thr = phase_thresholds[p];
      end else begin
        thr = sample_t'($urandom_range(0, 32'h0004_0000));
      end
      write_threshold(thr);
      phase_count = 0;
      run_len = $urandom_range(Depth + 1, Depth + 6);
      while (phase_count < PhaseWords) begin
        for (int i = 0; i < run_len; i++) begin
          send_word(pick_sample(), i == run_len - 1, 1'b0, none);
        end
        phase_count += run_len;
        run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(Depth - 2, Depth + 8)
                                              : $urandom_range(1, 8);
      end
      drain();
    end

    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Timeout far beyond the slowest correct run.
  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
